@@ rtl/tpsc_pkg.sv @@
// Shared types, constants and helpers for the two-point similarity calibration block.
// Depends on nothing; every rtl module refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tpsc_pkg;

  // field widths
  localparam int CW  = 48;            // coordinate and matrix entry width
  localparam int DW  = CW + 1;        // exact difference width
  localparam int PW  = 2 * DW;        // signed product width
  localparam int SW  = PW - 1;        // unsigned sum of squares width
  localparam int RW  = 26;            // rotation width
  localparam int ZW  = 30;            // cordic angle accumulator width, degrees Q.20
  localparam int XW  = 52;            // cordic vector width

  // pipeline depths
  localparam int MUL_LAT    = 2;
  localparam int DIV_STEPS  = 96;
  localparam int SQRT_STEPS = DIV_STEPS / 2;
  localparam int CORDIC_N   = 27;
  localparam int CORDIC_LAT = CORDIC_N + 1;

  // age of each stage, counted in advancing cycles after the item is taken
  localparam int AGE_A    = 1;
  localparam int AGE_D    = AGE_A + MUL_LAT + 1;
  localparam int AGE_E    = AGE_D + 1;
  localparam int AGE_F    = AGE_E + 1;
  localparam int AGE_G    = AGE_F + DIV_STEPS + 1;
  localparam int AGE_OFF  = AGE_G + MUL_LAT + 2;
  localparam int AGE_ROT  = AGE_A + CORDIC_LAT + 2;
  localparam int AGE_LAST = AGE_G + SQRT_STEPS;
  localparam int AGE_OUT  = AGE_LAST + 1;

  // limits
  localparam logic [CW-1:0] MAX_M     = 48'h7FFF_FFFF_FFFF;
  localparam logic [CW-1:0] MIN_OFF   = 48'h8000_0000_0000;
  localparam logic [CW-1:0] MAX_SCALE = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [RW:0] ROT_LIMIT = 27'sd23592960;
  localparam logic signed [ZW-1:0] QUARTER = 30'sd94371840;  // 90 degrees, Q.20

  // arctan(2^-i) in degrees, Q.20
  localparam int ATAN_TAB [0:CORDIC_N-1] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
    469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
    458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  typedef struct packed {
    logic signed [CW-1:0] pax;
    logic signed [CW-1:0] pay;
    logic signed [CW-1:0] wax;
    logic signed [CW-1:0] way;
    logic                 degen;
  } side_t;

  typedef struct packed {
    logic sat_d;
    logic sat_c;
    logic sat_s;
    logic neg_d;
    logic neg_c;
  } flag_t;

  typedef struct packed {
    logic signed [CW-1:0] mc;
    logic signed [CW-1:0] ms;
    logic signed [CW-1:0] mxy;
    logic                 sat_s;
    logic                 degen;
  } mat_t;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
  } off_t;

  // round a Q.80 quotient to Q.32, halves away from zero, saturate and apply sign
  function automatic logic signed [CW-1:0] ratio_fix(input logic [DIV_STEPS-1:0] q,
                                                      input logic sat, input logic neg);
    logic [CW:0]   val;
    logic [CW-1:0] mag;
    val = {1'b0, q[DIV_STEPS-1 -: CW]} + {{CW{1'b0}}, q[DIV_STEPS-CW-1]};
    if (sat || val > {1'b0, MAX_M}) mag = MAX_M;
    else mag = val[CW-1:0];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // saturate an offset sum in Q.48 to Q.16
  function automatic logic signed [CW-1:0] off_fix(input logic signed [PW-1:0] s);
    logic [PW-CW-32:0] top;
    top = s[PW-1:CW+31];
    if (top == '0 || top == '1) return s[CW+31:32];
    return s[PW-1] ? MIN_OFF : MAX_M;
  endfunction

endpackage

`default_nettype wire

@@ rtl/two_point_similarity_calibration.sv @@
// Top level of the two-point similarity calibration pipeline.
// Depends on tpsc_pkg, tpsc_smul, tpsc_udiv, tpsc_isqrt and tpsc_cordic.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per cycle (two points in picture and world coordinates) and
// returns one item per item: the scaled rotation matrix, the translation, the
// negated rotation angle and the scale. The depth from the input handshake to the
// output register is set by the 96-stage restoring divider (one quotient bit per
// stage) followed by the 48-stage square root. The whole pipeline advances
// whenever the output register is empty or being taken, so a stall holds every
// item in place. When the two picture points coincide the item comes out with
// m_tuser set and all data fields zero.
module two_point_similarity_calibration (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // pic_ax, pic_ay, pic_bx, pic_by, world_ax, world_ay, world_bx, world_by
  input  wire  [383:0] s_tdata,
  output logic         m_tvalid,
  input  wire          m_tready,
  // m_xx, m_xy, m_yx, m_yy, offset_x, offset_y, rotation_deg, scale_factor, zero pad
  output logic [367:0] m_tdata,
  // degenerate
  output logic         m_tuser
);

  localparam int CW = tpsc_pkg::CW;
  localparam int DW = tpsc_pkg::DW;
  localparam int PW = tpsc_pkg::PW;
  localparam int SW = tpsc_pkg::SW;
  localparam int RW = tpsc_pkg::RW;
  localparam int ZW = tpsc_pkg::ZW;
  localparam int QW = tpsc_pkg::DIV_STEPS;

  logic adv;
  logic [tpsc_pkg::AGE_OUT:1] vld;

  assign adv      = ~m_tvalid | m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[tpsc_pkg::AGE_OUT];

  // valid bits travel with the items
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[tpsc_pkg::AGE_OUT-1:1], s_tvalid};
    end
  end

  // input fields
  logic signed [CW-1:0] pic_ax, pic_ay, pic_bx, pic_by;
  logic signed [CW-1:0] world_ax, world_ay, world_bx, world_by;

  assign pic_ax   = s_tdata[47:0];
  assign pic_ay   = s_tdata[95:48];
  assign pic_bx   = s_tdata[143:96];
  assign pic_by   = s_tdata[191:144];
  assign world_ax = s_tdata[239:192];
  assign world_ay = s_tdata[287:240];
  assign world_bx = s_tdata[335:288];
  assign world_by = s_tdata[383:336];

  // stage a: segment differences
  logic signed [DW-1:0] pdx, pdy, wdx, wdy;
  tpsc_pkg::side_t      side_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      pdx          <= DW'(pic_bx) - DW'(pic_ax);
      pdy          <= DW'(pic_by) - DW'(pic_ay);
      wdx          <= DW'(world_bx) - DW'(world_ax);
      wdy          <= DW'(world_by) - DW'(world_ay);
      side_a.pax   <= pic_ax;
      side_a.pay   <= pic_ay;
      side_a.wax   <= world_ax;
      side_a.way   <= world_ay;
      side_a.degen <= (pic_ax == pic_bx) && (pic_ay == pic_by);
    end
  end

  // squares, dot and cross products
  logic signed [PW-1:0] p_pxx, p_pyy, p_wxx, p_wyy, p_dx, p_dy, p_cx, p_cy;

  tpsc_smul u_mul_pxx (.clk(clk), .en(adv), .a(pdx), .b(pdx), .p(p_pxx));
  tpsc_smul u_mul_pyy (.clk(clk), .en(adv), .a(pdy), .b(pdy), .p(p_pyy));
  tpsc_smul u_mul_wxx (.clk(clk), .en(adv), .a(wdx), .b(wdx), .p(p_wxx));
  tpsc_smul u_mul_wyy (.clk(clk), .en(adv), .a(wdy), .b(wdy), .p(p_wyy));
  tpsc_smul u_mul_dx  (.clk(clk), .en(adv), .a(wdx), .b(pdx), .p(p_dx));
  tpsc_smul u_mul_dy  (.clk(clk), .en(adv), .a(wdy), .b(pdy), .p(p_dy));
  tpsc_smul u_mul_cx  (.clk(clk), .en(adv), .a(pdx), .b(wdy), .p(p_cx));
  tpsc_smul u_mul_cy  (.clk(clk), .en(adv), .a(pdy), .b(wdx), .p(p_cy));

  // segment angles
  logic signed [ZW-1:0] zp, zw;

  tpsc_cordic u_cordic_pic   (.clk(clk), .en(adv), .x(pdx), .y(pdy), .z(zp));
  tpsc_cordic u_cordic_world (.clk(clk), .en(adv), .x(wdx), .y(wdy), .z(zw));

  // stage d: sums of products
  logic [SW-1:0]        d_len, wn_d;
  logic signed [PW-1:0] dot, crs;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_len <= p_pxx[SW-1:0] + p_pyy[SW-1:0];
      wn_d  <= p_wxx[SW-1:0] + p_wyy[SW-1:0];
      dot   <= p_dx + p_dy;
      crs   <= p_cx - p_cy;
    end
  end

  // stage e: magnitudes and signs
  logic signed [PW-1:0] dot_neg, crs_neg;
  logic [SW-1:0]        nd, nc, d_e, wn_e;
  logic                 neg_d_e, neg_c_e;

  assign dot_neg = -dot;
  assign crs_neg = -crs;

  always_ff @(posedge clk) begin
    if (adv) begin
      nd      <= dot[PW-1] ? dot_neg[SW-1:0] : dot[SW-1:0];
      nc      <= crs[PW-1] ? crs_neg[SW-1:0] : crs[SW-1:0];
      neg_d_e <= dot[PW-1];
      neg_c_e <= crs[PW-1];
      d_e     <= d_len;
      wn_e    <= wn_d;
    end
  end

  // stage f: overflow checks and divider setup
  logic [SW-1:0]   r0_d, r0_c, r0_s, d_f;
  logic [QW-1:0]   t_d, t_c, t_s;
  tpsc_pkg::flag_t fl_f;

  always_ff @(posedge clk) begin
    if (adv) begin
      fl_f.sat_d <= {16'b0, nd} >= {d_e, 16'b0};
      fl_f.sat_c <= {16'b0, nc} >= {d_e, 16'b0};
      fl_f.sat_s <= {32'b0, wn_e} >= {d_e, 32'b0};
      fl_f.neg_d <= neg_d_e;
      fl_f.neg_c <= neg_c_e;
      r0_d       <= {16'b0, nd[SW-1:16]};
      r0_c       <= {16'b0, nc[SW-1:16]};
      r0_s       <= {32'b0, wn_e[SW-1:32]};
      t_d        <= {nd[15:0], 80'b0};
      t_c        <= {nc[15:0], 80'b0};
      t_s        <= {wn_e[31:0], 64'b0};
      d_f        <= d_e;
    end
  end

  // quotients: dot and cross over length squared in Q.80, world over picture in Q.64
  logic [QW-1:0] q_d, q_c, q_s;

  tpsc_udiv u_div_dot   (.clk(clk), .en(adv), .r0(r0_d), .tail(t_d), .d(d_f), .q(q_d));
  tpsc_udiv u_div_cross (.clk(clk), .en(adv), .r0(r0_c), .tail(t_c), .d(d_f), .q(q_c));
  tpsc_udiv u_div_scale (.clk(clk), .en(adv), .r0(r0_s), .tail(t_s), .d(d_f), .q(q_s));

  // side data delay up to the divider outputs
  tpsc_pkg::side_t side_d [tpsc_pkg::AGE_A+1:tpsc_pkg::AGE_G-1];
  tpsc_pkg::flag_t fl_d   [tpsc_pkg::AGE_F+1:tpsc_pkg::AGE_G-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[tpsc_pkg::AGE_A+1] <= side_a;
      for (int k = tpsc_pkg::AGE_A + 2; k <= tpsc_pkg::AGE_G - 1; k++) begin
        side_d[k] <= side_d[k-1];
      end
      fl_d[tpsc_pkg::AGE_F+1] <= fl_f;
      for (int k = tpsc_pkg::AGE_F + 2; k <= tpsc_pkg::AGE_G - 1; k++) begin
        fl_d[k] <= fl_d[k-1];
      end
    end
  end

  // stage g: round the matrix entries
  tpsc_pkg::side_t      side_g;
  tpsc_pkg::flag_t      fl_g;
  tpsc_pkg::mat_t       mat_g;
  logic [QW-1:0]        q_sg;
  logic signed [CW-1:0] mc_n, ms_n;

  assign side_g = side_d[tpsc_pkg::AGE_G-1];
  assign fl_g   = fl_d[tpsc_pkg::AGE_G-1];
  assign mc_n   = tpsc_pkg::ratio_fix(q_d, fl_g.sat_d, fl_g.neg_d);
  assign ms_n   = tpsc_pkg::ratio_fix(q_c, fl_g.sat_c, fl_g.neg_c);

  logic signed [CW-1:0] pax_g, pay_g, wax_g, way_g;

  always_ff @(posedge clk) begin
    if (adv) begin
      mat_g.mc    <= mc_n;
      mat_g.ms    <= ms_n;
      mat_g.mxy   <= -ms_n;
      mat_g.sat_s <= fl_g.sat_s;
      mat_g.degen <= side_g.degen;
      q_sg        <= q_s;
      pax_g       <= side_g.pax;
      pay_g       <= side_g.pay;
      wax_g       <= side_g.wax;
      way_g       <= side_g.way;
    end
  end

  // scale root
  logic [CW-1:0] root;

  tpsc_isqrt u_sqrt (.clk(clk), .en(adv), .v(q_sg), .root(root));

  // offset products with the rounded matrix
  logic signed [PW-1:0] o_xx, o_xy, o_yx, o_yy;

  tpsc_smul u_mul_oxx (.clk(clk), .en(adv), .a(DW'(mat_g.mc)), .b(DW'(pax_g)), .p(o_xx));
  tpsc_smul u_mul_oxy (.clk(clk), .en(adv), .a(DW'(mat_g.mxy)), .b(DW'(pay_g)), .p(o_xy));
  tpsc_smul u_mul_oyx (.clk(clk), .en(adv), .a(DW'(mat_g.ms)), .b(DW'(pax_g)), .p(o_yx));
  tpsc_smul u_mul_oyy (.clk(clk), .en(adv), .a(DW'(mat_g.mc)), .b(DW'(pay_g)), .p(o_yy));

  // world point delay alongside the offset products
  logic signed [CW-1:0] wax_d [1:tpsc_pkg::MUL_LAT];
  logic signed [CW-1:0] way_d [1:tpsc_pkg::MUL_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      wax_d[1] <= wax_g;
      way_d[1] <= way_g;
      for (int k = 2; k <= tpsc_pkg::MUL_LAT; k++) begin
        wax_d[k] <= wax_d[k-1];
        way_d[k] <= way_d[k-1];
      end
    end
  end

  // stage h: offset sums in Q.48 with the rounding half
  logic signed [PW-1:0] sx, sy, wxs, wys;

  assign wxs = {{(PW-CW-32){wax_d[tpsc_pkg::MUL_LAT][CW-1]}}, wax_d[tpsc_pkg::MUL_LAT], 32'b0};
  assign wys = {{(PW-CW-32){way_d[tpsc_pkg::MUL_LAT][CW-1]}}, way_d[tpsc_pkg::MUL_LAT], 32'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      sx <= wxs - o_xx - o_xy + (PW'(1) << 31);
      sy <= wys - o_yx - o_yy + (PW'(1) << 31);
    end
  end

  // stage i: saturate offsets
  tpsc_pkg::off_t off_i;

  always_ff @(posedge clk) begin
    if (adv) begin
      off_i.ox <= tpsc_pkg::off_fix(sx);
      off_i.oy <= tpsc_pkg::off_fix(sy);
    end
  end

  // rotation: angle difference, round to Q.16, clamp
  logic signed [RW:0]   rdiff;
  logic signed [RW-1:0] rot;
  logic signed [ZW:0]   zdiff;

  assign zdiff = (ZW+1)'(zp) - (ZW+1)'(zw) + (ZW+1)'(8);

  always_ff @(posedge clk) begin
    if (adv) begin
      rdiff <= (RW+1)'(zdiff >>> 4);
      if (rdiff > tpsc_pkg::ROT_LIMIT) rot <= RW'(tpsc_pkg::ROT_LIMIT);
      else if (rdiff < -tpsc_pkg::ROT_LIMIT) rot <= RW'(-tpsc_pkg::ROT_LIMIT);
      else rot <= rdiff[RW-1:0];
    end
  end

  // align matrix, offsets and rotation with the root
  tpsc_pkg::mat_t       mat_d [tpsc_pkg::AGE_G+1:tpsc_pkg::AGE_LAST];
  tpsc_pkg::off_t       off_d [tpsc_pkg::AGE_OFF+1:tpsc_pkg::AGE_LAST];
  logic signed [RW-1:0] rot_d [tpsc_pkg::AGE_ROT+1:tpsc_pkg::AGE_LAST];

  always_ff @(posedge clk) begin
    if (adv) begin
      mat_d[tpsc_pkg::AGE_G+1] <= mat_g;
      for (int k = tpsc_pkg::AGE_G + 2; k <= tpsc_pkg::AGE_LAST; k++) begin
        mat_d[k] <= mat_d[k-1];
      end
      off_d[tpsc_pkg::AGE_OFF+1] <= off_i;
      for (int k = tpsc_pkg::AGE_OFF + 2; k <= tpsc_pkg::AGE_LAST; k++) begin
        off_d[k] <= off_d[k-1];
      end
      rot_d[tpsc_pkg::AGE_ROT+1] <= rot;
      for (int k = tpsc_pkg::AGE_ROT + 2; k <= tpsc_pkg::AGE_LAST; k++) begin
        rot_d[k] <= rot_d[k-1];
      end
    end
  end

  // output register
  tpsc_pkg::mat_t       mat_l;
  tpsc_pkg::off_t       off_l;
  logic signed [CW-1:0] m_xx, m_xy, m_yx, m_yy, offset_x, offset_y;
  logic signed [RW-1:0] rotation_deg;
  logic [CW-1:0]        scale_factor;

  assign mat_l = mat_d[tpsc_pkg::AGE_LAST];
  assign off_l = off_d[tpsc_pkg::AGE_LAST];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (mat_l.degen) begin
        m_xx         <= '0;
        m_xy         <= '0;
        m_yx         <= '0;
        m_yy         <= '0;
        offset_x     <= '0;
        offset_y     <= '0;
        rotation_deg <= '0;
        scale_factor <= '0;
        m_tuser      <= 1'b1;
      end else begin
        m_xx         <= mat_l.mc;
        m_xy         <= mat_l.mxy;
        m_yx         <= mat_l.ms;
        m_yy         <= mat_l.mc;
        offset_x     <= off_l.ox;
        offset_y     <= off_l.oy;
        rotation_deg <= rot_d[tpsc_pkg::AGE_LAST];
        scale_factor <= mat_l.sat_s ? tpsc_pkg::MAX_SCALE : root;
        m_tuser      <= 1'b0;
      end
    end
  end

  assign m_tdata = {6'b0, scale_factor, rotation_deg, offset_y, offset_x,
                    m_yy, m_yx, m_xy, m_xx};

endmodule

`default_nettype wire

@@ rtl/tpsc_smul.sv @@
// Two-stage signed 49 x 49 multiplier built from four narrow partial products.
// Depends on tpsc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_smul (
  input  wire                                clk,
  input  wire                                en,
  input  wire  logic signed [tpsc_pkg::DW-1:0] a,
  input  wire  logic signed [tpsc_pkg::DW-1:0] b,
  output logic signed [tpsc_pkg::PW-1:0]     p
);

  logic [24:0]        al, bl;
  logic signed [23:0] ah, bh;
  logic [49:0]        pll;
  logic signed [49:0] plh, phl;
  logic signed [47:0] phh;
  logic [50:0]        mid;

  assign al = a[24:0];
  assign bl = b[24:0];
  assign ah = a[48:25];
  assign bh = b[48:25];

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pll <= al * bl;
      plh <= $signed({1'b0, al}) * bh;
      phl <= ah * $signed({1'b0, bl});
      phh <= ah * bh;
    end
  end

  assign mid = {plh[49], plh} + {phl[49], phl};

  // recombine
  always_ff @(posedge clk) begin
    if (en) begin
      p <= {phh, 50'b0} + {{22{mid[50]}}, mid, 25'b0} + {48'b0, pll};
    end
  end

endmodule

`default_nettype wire

@@ rtl/tpsc_udiv.sv @@
// Pipelined restoring divider, one quotient bit per stage, 96 stages.
// Depends on tpsc_pkg for widths and depth.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_udiv (
  input  wire                                  clk,
  input  wire                                  en,
  input  wire  logic [tpsc_pkg::SW-1:0]        r0,    // starting remainder, below d
  input  wire  logic [tpsc_pkg::DIV_STEPS-1:0] tail,  // dividend bits, msb first
  input  wire  logic [tpsc_pkg::SW-1:0]        d,
  output logic [tpsc_pkg::DIV_STEPS-1:0]       q
);

  localparam int N = tpsc_pkg::DIV_STEPS;
  localparam int W = tpsc_pkg::SW;

  logic [W-1:0] rem [0:N-1];
  logic [N-1:0] tl  [0:N-1];
  logic [W-1:0] dv  [0:N-1];
  logic [N-1:0] qq  [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [W-1:0] r_prev, d_prev;
    logic [N-1:0] t_prev, q_prev;
    logic [W:0]   rs;
    logic         ge;

    if (k == 0) begin : g_first
      assign r_prev = r0;
      assign t_prev = tail;
      assign d_prev = d;
      assign q_prev = '0;
    end else begin : g_next
      assign r_prev = rem[k-1];
      assign t_prev = tl[k-1];
      assign d_prev = dv[k-1];
      assign q_prev = qq[k-1];
    end

    // shift in the next dividend bit and try a subtract
    assign rs = {r_prev, t_prev[N-1]};
    assign ge = rs >= {1'b0, d_prev};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? W'(rs - {1'b0, d_prev}) : rs[W-1:0];
        tl[k]  <= {t_prev[N-2:0], 1'b0};
        dv[k]  <= d_prev;
        qq[k]  <= {q_prev[N-2:0], ge};
      end
    end
  end

  assign q = qq[N-1];

endmodule

`default_nettype wire

@@ rtl/tpsc_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, 48 stages.
// Depends on tpsc_pkg for widths and depth.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_isqrt (
  input  wire                                  clk,
  input  wire                                  en,
  input  wire  logic [tpsc_pkg::DIV_STEPS-1:0] v,
  output logic [tpsc_pkg::CW-1:0]              root
);

  localparam int N  = tpsc_pkg::SQRT_STEPS;
  localparam int VW = tpsc_pkg::DIV_STEPS;

  logic [N:0]    rm [0:N-1];
  logic [N-1:0]  rt [0:N-1];
  logic [VW-1:0] vv [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [N:0]    m_prev;
    logic [N-1:0]  t_prev;
    logic [VW-1:0] v_prev;
    logic [N+2:0]  rs, trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign m_prev = '0;
      assign t_prev = '0;
      assign v_prev = v;
    end else begin : g_next
      assign m_prev = rm[k-1];
      assign t_prev = rt[k-1];
      assign v_prev = vv[k-1];
    end

    // bring down two bits and test root*4+1
    assign rs    = {m_prev, v_prev[VW-1 -: 2]};
    assign trial = {1'b0, t_prev, 2'b01};
    assign ge    = rs >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k] <= ge ? (N+1)'(rs - trial) : rs[N:0];
        rt[k] <= {t_prev[N-2:0], ge};
        vv[k] <= {v_prev[VW-3:0], 2'b00};
      end
    end
  end

  assign root = rt[N-1];

endmodule

`default_nettype wire

@@ rtl/tpsc_cordic.sv @@
// Pipelined vectoring cordic: atan2 in degrees Q.20, quadrant fold then 27 stages.
// Depends on tpsc_pkg for widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_cordic (
  input  wire                                  clk,
  input  wire                                  en,
  input  wire  logic signed [tpsc_pkg::DW-1:0] x,
  input  wire  logic signed [tpsc_pkg::DW-1:0] y,
  output logic signed [tpsc_pkg::ZW-1:0]       z
);

  localparam int N  = tpsc_pkg::CORDIC_N;
  localparam int XW = tpsc_pkg::XW;
  localparam int ZW = tpsc_pkg::ZW;

  logic signed [XW-1:0] xr [0:N];
  logic signed [XW-1:0] yr [0:N];
  logic signed [ZW-1:0] zr [0:N];
  logic                 zero [0:N];

  logic signed [XW-1:0] xe, ye;

  assign xe = XW'(x);
  assign ye = XW'(y);

  // fold the left half plane by plus or minus 90 degrees
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x == '0) && (y == '0);
      if (x < 0 && y >= 0) begin
        xr[0] <= ye;
        yr[0] <= -xe;
        zr[0] <= tpsc_pkg::QUARTER;
      end else if (x < 0) begin
        xr[0] <= -ye;
        yr[0] <= xe;
        zr[0] <= -tpsc_pkg::QUARTER;
      end else begin
        xr[0] <= xe;
        yr[0] <= ye;
        zr[0] <= '0;
      end
    end
  end

  // micro-rotations toward the x axis
  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;

    assign xs = xr[i] >>> i;
    assign ys = yr[i] >>> i;
    assign at = ZW'(tpsc_pkg::ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (yr[i] >= 0) begin
          xr[i+1] <= xr[i] + ys;
          yr[i+1] <= yr[i] - xs;
          zr[i+1] <= zr[i] + at;
        end else begin
          xr[i+1] <= xr[i] - ys;
          yr[i+1] <= yr[i] + xs;
          zr[i+1] <= zr[i] - at;
        end
      end
    end
  end

  // a zero vector has angle zero
  assign z = zero[N] ? '0 : zr[N];

endmodule

`default_nettype wire
